@@ hdl/ckb_pkg.sv @@
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types and constants of the chroma key soft blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ckb_pkg;

   // YCrCb transform, 14-bit integer coefficients
   localparam int unsigned YC_SHIFT   = 14;
   localparam int unsigned YC_HALF    = 8192;
   localparam int unsigned COEF_BY    = 1868;
   localparam int unsigned COEF_GY    = 9617;
   localparam int unsigned COEF_RY    = 4899;
   localparam int unsigned COEF_CR    = 11682;
   localparam int unsigned COEF_CB    = 9241;
   localparam int unsigned CHROMA_MID = 128;

   // distance and matte formats
   localparam int unsigned DIST_FRAC  = 4;    // fractional bits of the distance
   localparam int unsigned DIST_W     = 13;   // 0..5770 with 4 fractional bits
   localparam int unsigned ALPHA_BITS = 10;   // Q0.10
   localparam int unsigned ALPHA_W    = ALPHA_BITS + 1;  // 0..1024

   // configuration port
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [8:0]  INNER_RESET = 9'd30;
   localparam logic [8:0]  OUTER_RESET = 9'd50;

   // default queue depths
   localparam int unsigned MID_DEPTH_DEF = 4;
   localparam int unsigned OUT_DEPTH_DEF = 2;

   typedef enum logic [1:0] {
      CSR_KEY_CR = 2'd0,
      CSR_KEY_CB = 2'd1,
      CSR_INNER  = 2'd2,
      CSR_OUTER  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_BG    = 2'd0,
      REGION_FG    = 2'd1,
      REGION_BLEND = 2'd2
   } region_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type fg;
      pixel_type bg;
   } pair_type;

   typedef struct packed {
      logic [7:0] key_cr;
      logic [7:0] key_cb;
      logic [8:0] inner_threshold;
      logic [8:0] outer_threshold;
   } cfg_type;

   // classified pixel pair handed from the front to the back
   typedef struct packed {
      pair_type          pair;
      region_type        region;
      logic [DIST_W-1:0] num;   // d4 - in4
      logic [DIST_W-1:0] den;   // out4 - in4
   } matte_type;

   typedef struct packed {
      pixel_type  pix;
      region_type region;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/ckb_fifo.sv @@
// ----------------------------------------------------------------------------
// ckb_fifo
// Small register queue with count, used between the pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ckb_csr.sv @@
// ----------------------------------------------------------------------------
// ckb_csr
// APB register file holding the key chroma and the two matte thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_csr
   import ckb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   csr_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_cr          <= '0;
         cfg_ff.key_cb          <= '0;
         cfg_ff.inner_threshold <= INNER_RESET;
         cfg_ff.outer_threshold <= OUTER_RESET;
      end else if (wr_en) begin
         unique case (index)
            CSR_KEY_CR: cfg_ff.key_cr          <= pwdata[7:0];
            CSR_KEY_CB: cfg_ff.key_cb          <= pwdata[7:0];
            CSR_INNER:  cfg_ff.inner_threshold <= pwdata[8:0];
            CSR_OUTER:  cfg_ff.outer_threshold <= pwdata[8:0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         CSR_KEY_CR: prdata = CSR_DATA_W'(cfg_ff.key_cr);
         CSR_KEY_CB: prdata = CSR_DATA_W'(cfg_ff.key_cb);
         CSR_INNER:  prdata = CSR_DATA_W'(cfg_ff.inner_threshold);
         CSR_OUTER:  prdata = CSR_DATA_W'(cfg_ff.outer_threshold);
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/ckb_front.sv @@
// ----------------------------------------------------------------------------
// ckb_front
// Front pipeline: YCrCb chroma, key distance, square root and region
// classification. All stages advance together unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_front
   import ckb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   input  wire pair_type in_pair,
   output logic          in_ready,
   output logic          out_valid,
   output matte_type     out_item,
   input  wire logic     out_full
);

   localparam int unsigned SQRT_STEPS = DIST_W;
   localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
   localparam int unsigned REM_W      = DIST_W + 3;
   localparam int unsigned SUM_W      = 17;
   localparam int unsigned YSUM_W     = 22;
   localparam int unsigned ACC_W      = 24;

   localparam logic [YSUM_W-1:0] C_BY   = YSUM_W'(COEF_BY);
   localparam logic [YSUM_W-1:0] C_GY   = YSUM_W'(COEF_GY);
   localparam logic [YSUM_W-1:0] C_RY   = YSUM_W'(COEF_RY);
   localparam logic [YSUM_W-1:0] C_HALF = YSUM_W'(YC_HALF);
   localparam logic signed [ACC_W-1:0] C_CR   = ACC_W'(COEF_CR);
   localparam logic signed [ACC_W-1:0] C_CB   = ACC_W'(COEF_CB);
   localparam logic signed [ACC_W-1:0] C_BIAS = ACC_W'(CHROMA_MID * (2 ** YC_SHIFT) + YC_HALF);

   // floor by 2^14 and clamp to 0..255
   function automatic logic [7:0] clamp_chroma(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-YC_SHIFT-1:0] q;
      q = acc[ACC_W-1:YC_SHIFT];
      if (acc[ACC_W-1]) begin
         return 8'd0;
      end else if (q > (ACC_W-YC_SHIFT)'(255)) begin
         return 8'd255;
      end else begin
         return q[7:0];
      end
   endfunction

   logic en;

   assign en        = !(out_valid && out_full);
   assign in_ready  = en;

   // ---- stage 1: luma --------------------------------------------------
   logic              v1_ff;
   pair_type          pair1_ff;
   logic [7:0]        y1_ff;
   logic [YSUM_W-1:0] ysum;

   assign ysum = C_BY * YSUM_W'(in_pair.fg.blue) + C_GY * YSUM_W'(in_pair.fg.green)
               + C_RY * YSUM_W'(in_pair.fg.red) + C_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         pair1_ff <= in_pair;
         y1_ff    <= ysum[YSUM_W-1:YC_SHIFT];
      end
   end

   // ---- stage 2: Cr and Cb ---------------------------------------------
   logic                    v2_ff;
   pair_type                pair2_ff;
   logic [7:0]              cr2_ff, cb2_ff;
   logic signed [8:0]       dr, db;
   logic signed [ACC_W-1:0] acc_cr, acc_cb;

   assign dr     = $signed({1'b0, pair1_ff.fg.red})  - $signed({1'b0, y1_ff});
   assign db     = $signed({1'b0, pair1_ff.fg.blue}) - $signed({1'b0, y1_ff});
   assign acc_cr = ACC_W'(dr) * C_CR + C_BIAS;
   assign acc_cb = ACC_W'(db) * C_CB + C_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         pair2_ff <= pair1_ff;
         cr2_ff   <= clamp_chroma(acc_cr);
         cb2_ff   <= clamp_chroma(acc_cb);
      end
   end

   // ---- stage 3: squared chroma distance -------------------------------
   logic               v3_ff;
   pair_type           pair3_ff;
   logic [SUM_W-1:0]   sq3_ff;
   logic signed [8:0]  dcr, dcb;
   logic signed [17:0] pcr, pcb;

   assign dcr = $signed({1'b0, cr2_ff}) - $signed({1'b0, cfg.key_cr});
   assign dcb = $signed({1'b0, cb2_ff}) - $signed({1'b0, cfg.key_cb});
   assign pcr = dcr * dcr;
   assign pcb = dcb * dcb;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         pair3_ff <= pair2_ff;
         sq3_ff   <= {1'b0, pcr[15:0]} + {1'b0, pcb[15:0]};
      end
   end

   // ---- square root, one result bit per stage --------------------------
   logic              sv_ff    [SQRT_STEPS];
   pair_type          spair_ff [SQRT_STEPS];
   logic [RAD_W-1:0]  srad_ff  [SQRT_STEPS];
   logic [REM_W-1:0]  srem_ff  [SQRT_STEPS];
   logic [DIST_W-1:0] sroot_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic              src_v;
      pair_type          src_pair;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [DIST_W-1:0] src_root;
      logic [REM_W-1:0]  rem_sh, test;
      logic              take;

      if (k == 0) begin : g_first
         // radicand is the squared distance scaled by 2^(2*DIST_FRAC)
         assign src_v    = v3_ff;
         assign src_pair = pair3_ff;
         assign src_rad  = RAD_W'({sq3_ff, {(2 * DIST_FRAC){1'b0}}});
         assign src_rem  = '0;
         assign src_root = '0;
      end else begin : g_next
         assign src_v    = sv_ff[k-1];
         assign src_pair = spair_ff[k-1];
         assign src_rad  = srad_ff[k-1];
         assign src_rem  = srem_ff[k-1];
         assign src_root = sroot_ff[k-1];
      end

      assign rem_sh = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      assign test   = REM_W'({src_root, 2'b01});
      assign take   = (rem_sh >= test);

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= src_v;
         end
         if (en) begin
            spair_ff[k] <= src_pair;
            srad_ff[k]  <= {src_rad[RAD_W-3:0], 2'b00};
            srem_ff[k]  <= take ? rem_sh - test : rem_sh;
            sroot_ff[k] <= {src_root[DIST_W-2:0], take};
         end
      end
   end

   // ---- classify against the thresholds --------------------------------
   logic              vc_ff;
   matte_type         item_ff;
   logic [DIST_W-1:0] d4, in4, out4;
   region_type        region;

   assign d4   = sroot_ff[SQRT_STEPS-1];
   assign in4  = {cfg.inner_threshold, DIST_FRAC'(0)};
   assign out4 = {cfg.outer_threshold, DIST_FRAC'(0)};

   always_comb begin
      priority if (d4 < in4) begin
         region = REGION_BG;
      end else if (d4 > out4 || cfg.outer_threshold <= cfg.inner_threshold) begin
         region = REGION_FG;
      end else begin
         region = REGION_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= sv_ff[SQRT_STEPS-1];
      end
      if (en) begin
         item_ff.pair   <= spair_ff[SQRT_STEPS-1];
         item_ff.region <= region;
         item_ff.num    <= d4 - in4;
         item_ff.den    <= out4 - in4;
      end
   end

   assign out_valid = vc_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

@@ hdl/ckb_back.sv @@
// ----------------------------------------------------------------------------
// ckb_back
// Back pipeline: alpha by restoring division, one quotient bit per stage,
// then the per-channel linear mix with round to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module ckb_back
   import ckb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_empty,
   input  wire matte_type in_item,
   output logic           in_pop,
   output logic           out_valid,
   output result_type     out_item,
   input  wire logic      out_full
);

   localparam int unsigned DIV_STEPS = ALPHA_W;
   localparam int unsigned REM_W     = DIST_W + 1;
   localparam int unsigned MIX_W     = 8 + ALPHA_BITS;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(2 ** ALPHA_BITS);
   localparam logic [MIX_W-1:0]   MIX_HALF  = MIX_W'(2 ** (ALPHA_BITS - 1));

   logic en;

   assign en     = !(out_valid && out_full);
   assign in_pop = en && !in_empty;

   // ---- alpha = floor(num * 2^10 / den) --------------------------------
   logic               dv_ff     [DIV_STEPS];
   pair_type           dpair_ff  [DIV_STEPS];
   region_type         dreg_ff   [DIV_STEPS];
   logic [DIST_W-1:0]  dden_ff   [DIV_STEPS];
   logic [REM_W-1:0]   drem_ff   [DIV_STEPS];
   logic [ALPHA_W-1:0] dquo_ff   [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic               src_v;
      pair_type           src_pair;
      region_type         src_reg;
      logic [DIST_W-1:0]  src_den;
      logic [REM_W-1:0]   rem_sh;
      logic [ALPHA_W-1:0] src_quo;
      logic               take;

      if (k == 0) begin : g_first
         // integer quotient bit: num never exceeds den in the band
         assign src_v    = !in_empty;
         assign src_pair = in_item.pair;
         assign src_reg  = in_item.region;
         assign src_den  = in_item.den;
         assign rem_sh   = {1'b0, in_item.num};
         assign src_quo  = '0;
      end else begin : g_next
         assign src_v    = dv_ff[k-1];
         assign src_pair = dpair_ff[k-1];
         assign src_reg  = dreg_ff[k-1];
         assign src_den  = dden_ff[k-1];
         assign rem_sh   = {drem_ff[k-1][REM_W-2:0], 1'b0};
         assign src_quo  = dquo_ff[k-1];
      end

      assign take = (rem_sh >= {1'b0, src_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= src_v;
         end
         if (en) begin
            dpair_ff[k] <= src_pair;
            dreg_ff[k]  <= src_reg;
            dden_ff[k]  <= src_den;
            drem_ff[k]  <= take ? rem_sh - {1'b0, src_den} : rem_sh;
            dquo_ff[k]  <= {src_quo[ALPHA_W-2:0], take};
         end
      end
   end

   // ---- blend and select -----------------------------------------------
   logic               bv_ff;
   result_type         res_ff;
   pair_type           bpair;
   logic [ALPHA_W-1:0] alpha, inv_alpha;
   logic [MIX_W-1:0]   mix_b, mix_g, mix_r;
   pixel_type          pix;

   assign bpair     = dpair_ff[DIV_STEPS-1];
   assign alpha     = dquo_ff[DIV_STEPS-1];
   assign inv_alpha = ALPHA_ONE - alpha;

   assign mix_b = MIX_W'(bpair.bg.blue)  * MIX_W'(inv_alpha)
                + MIX_W'(bpair.fg.blue)  * MIX_W'(alpha) + MIX_HALF;
   assign mix_g = MIX_W'(bpair.bg.green) * MIX_W'(inv_alpha)
                + MIX_W'(bpair.fg.green) * MIX_W'(alpha) + MIX_HALF;
   assign mix_r = MIX_W'(bpair.bg.red)   * MIX_W'(inv_alpha)
                + MIX_W'(bpair.fg.red)   * MIX_W'(alpha) + MIX_HALF;

   always_comb begin
      unique case (dreg_ff[DIV_STEPS-1])
         REGION_BG: pix = bpair.bg;
         REGION_BLEND: begin
            pix.blue  = mix_b[MIX_W-1:ALPHA_BITS];
            pix.green = mix_g[MIX_W-1:ALPHA_BITS];
            pix.red   = mix_r[MIX_W-1:ALPHA_BITS];
         end
         default: pix = bpair.fg;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
      end else if (en) begin
         bv_ff <= dv_ff[DIV_STEPS-1];
      end
      if (en) begin
         res_ff.pix    <= pix;
         res_ff.region <= dreg_ff[DIV_STEPS-1];
      end
   end

   assign out_valid = bv_ff;
   assign out_item  = res_ff;

endmodule

`default_nettype wire

@@ hdl/chroma_key_soft_blend_unit.sv @@
// ----------------------------------------------------------------------------
// chroma_key_soft_blend_unit
// Chroma key compositor with a soft matte, one foreground/background pixel
// pair per clock while full is low.
//
// Input: drive the req_ fields with push high; a transfer happens on a clock
// edge where full is low. Output: while empty is low the oldest result sits
// on the rsp_ ports; pop high transfers it.
// Throughput is one pixel pair per cycle while full is low. An input transfer
// reaches the result through 17 front stages (chroma, distance, 13-stage
// square root, classify), the middle queue, 11 division stages for alpha,
// the blend register and the result queue.
// When pop is held low the result queue fills, the back pipeline stops, the
// middle queue absorbs the front, and then full rises; nothing is dropped.
// Synchronous reset empties both queues and pipelines and loads the register
// reset values (key 0/0, thresholds 30 and 50). The APB port must be written
// by the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_key_soft_blend_unit
   import ckb_pkg::*;
#(
   parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
   parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input pixel pair
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [7:0]            req_fg_blue,
   input  wire logic [7:0]            req_fg_green,
   input  wire logic [7:0]            req_fg_red,
   input  wire logic [7:0]            req_bg_blue,
   input  wire logic [7:0]            req_bg_green,
   input  wire logic [7:0]            req_bg_red,
   // composited result
   output logic                       empty,
   input  wire logic                  pop,
   output logic      [7:0]            rsp_out_blue,
   output logic      [7:0]            rsp_out_green,
   output logic      [7:0]            rsp_out_red,
   output logic      [1:0]            rsp_region,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type    cfg;
   pair_type   in_pair;
   logic       front_ready;
   logic       front_valid;
   matte_type  front_item;
   logic       mid_full, mid_empty, mid_pop;
   matte_type  mid_item;
   logic       back_valid;
   result_type back_item;
   logic       res_full;
   result_type res_item;

   assign in_pair.fg.blue  = req_fg_blue;
   assign in_pair.fg.green = req_fg_green;
   assign in_pair.fg.red   = req_fg_red;
   assign in_pair.bg.blue  = req_bg_blue;
   assign in_pair.bg.green = req_bg_green;
   assign in_pair.bg.red   = req_bg_red;
   assign full             = !front_ready;

   // register file
   ckb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // chroma, distance and classification
   ckb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (push),
      .in_pair   (in_pair),
      .in_ready  (front_ready),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_full  (mid_full)
   );

   // decoupling queue between front and back
   ckb_fifo #(
      .WIDTH ($bits(matte_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   // alpha and blend
   ckb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (mid_empty),
      .in_item   (mid_item),
      .in_pop    (mid_pop),
      .out_valid (back_valid),
      .out_item  (back_item),
      .out_full  (res_full)
   );

   // result queue
   ckb_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_item),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (res_item),
      .empty     (empty)
   );

   assign rsp_out_blue  = res_item.pix.blue;
   assign rsp_out_green = res_item.pix.green;
   assign rsp_out_red   = res_item.pix.red;
   assign rsp_region    = res_item.region;

endmodule

`default_nettype wire
